FILE: src/dcas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcas_pkg
// Shared types for the direction-chosen array sort block.
// ----------------------------------------------------------------------------
package dcas_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned QUEUE_DEPTH = 2;

    // One classified item passed from the front to the back
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      store_en;
        logic                      last;
        logic                      descending;
        logic                      dropped;
    } entry_t;

endpackage

FILE: src/direction_chosen_array_sort_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direction_chosen_array_sort_top
// Loads a block of signed values, then emits them sorted, descending when the
// first maximum follows the first minimum and ascending otherwise.
// ----------------------------------------------------------------------------
//  channel  | handshake       | payload
//  ---------+-----------------+-----------------------------------------------
//  input    | start, busy     | value, last
//  result   | done (strobe)   | sorted_value, last_res, descending, dropped
//
//  An item is taken when start is high and busy is low; a two-entry queue
//  sits between the front and the sorting row, and busy is high while that
//  queue is full. After the last item of a block, ascending results follow
//  at one per cycle; descending results first wait while the sorting row
//  shifts its largest value to the top, then follow at one per cycle.
//  Reset clears all control state; stored values need none.
//  Results cannot be held off: each stands on the ports for one cycle.
// ----------------------------------------------------------------------------
module direction_chosen_array_sort_top #(
    parameter int unsigned CAPACITY = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [dcas_pkg::VALUE_W-1:0]   value,
    input  logic                                  last,
    output logic                                  done,
    output logic signed [dcas_pkg::VALUE_W-1:0]   sorted_value,
    output logic                                  last_res,
    output logic                                  descending,
    output logic                                  dropped
);

    dcas_pkg::entry_t  push_entry;
    dcas_pkg::entry_t  pop_entry;
    logic              accept;
    logic              pop;
    logic              full;
    logic              empty;

    assign busy   = full;
    assign accept = start && !busy;

    dcas_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .value  (value),
        .last   (last),
        .entry  (push_entry)
    );

    dcas_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .full       (full),
        .empty      (empty)
    );

    dcas_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .entry        (pop_entry),
        .pop          (pop),
        .done         (done),
        .sorted_value (sorted_value),
        .last_res     (last_res),
        .descending   (descending),
        .dropped      (dropped)
    );

`ifndef SYNTHESIS
    a_gap_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done && last_res |=> !done)
        else $error("result strobe directly after end of run");

    a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last_res |=> done)
        else $error("run of results broken before its last item");

    a_run_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last_res |=> descending == $past(descending) && dropped == $past(dropped))
        else $error("order or drop flag changed within a run");
`endif

endmodule

FILE: src/dcas_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcas_front
// Accepts items, tracks fill level, first maximum and first minimum positions
// and overflow, and classifies each item for the back end.
// ----------------------------------------------------------------------------
module dcas_front #(
    parameter int unsigned CAPACITY = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic signed [dcas_pkg::VALUE_W-1:0]   value,
    input  logic                                  last,
    output dcas_pkg::entry_t                      entry
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = $clog2(CAPACITY);

    logic [CW-1:0]                        count_reg, count_next;
    logic [PW-1:0]                        max_pos_reg, max_pos_next;
    logic [PW-1:0]                        min_pos_reg, min_pos_next;
    logic signed [dcas_pkg::VALUE_W-1:0]  max_seen_reg, max_seen_next;
    logic signed [dcas_pkg::VALUE_W-1:0]  min_seen_reg, min_seen_next;
    logic                                 overflow_reg, overflow_next;
    logic                                 store_en;
    logic [PW-1:0]                        pos;

    always_comb
    begin
        store_en      = (count_reg < CW'(CAPACITY));
        pos           = count_reg[PW-1:0];
        count_next    = count_reg;
        max_pos_next  = max_pos_reg;
        min_pos_next  = min_pos_reg;
        max_seen_next = max_seen_reg;
        min_seen_next = min_seen_reg;
        overflow_next = overflow_reg;

        if (store_en)
        begin
            count_next = count_reg + CW'(1);
            if (count_reg == '0)
            begin
                max_seen_next = value;
                min_seen_next = value;
                max_pos_next  = '0;
                min_pos_next  = '0;
            end
            else
            begin
                if (value > max_seen_reg)
                begin
                    max_seen_next = value;
                    max_pos_next  = pos;
                end
                if (value < min_seen_reg)
                begin
                    min_seen_next = value;
                    min_pos_next  = pos;
                end
            end
        end
        else
        begin
            overflow_next = 1'b1;
        end

        entry.value      = value;
        entry.store_en   = store_en;
        entry.last       = last;
        entry.descending = (max_pos_next > min_pos_next);
        entry.dropped    = overflow_next;

        // clear for the next block
        if (last)
        begin
            count_next    = '0;
            max_pos_next  = '0;
            min_pos_next  = '0;
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            max_pos_reg  <= '0;
            min_pos_reg  <= '0;
            overflow_reg <= 1'b0;
        end
        else if (accept)
        begin
            count_reg    <= count_next;
            max_pos_reg  <= max_pos_next;
            min_pos_reg  <= min_pos_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            max_seen_reg <= max_seen_next;
            min_seen_reg <= min_seen_next;
        end
    end

endmodule

FILE: src/dcas_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcas_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module dcas_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dcas_pkg::entry_t  push_entry,
    input  logic              pop,
    output dcas_pkg::entry_t  pop_entry,
    output logic              full,
    output logic              empty
);

    localparam int unsigned AW = $clog2(dcas_pkg::QUEUE_DEPTH);
    localparam int unsigned NW = $clog2(dcas_pkg::QUEUE_DEPTH + 1);

    dcas_pkg::entry_t  slots_reg [dcas_pkg::QUEUE_DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [NW-1:0]     fill_reg;

    assign full      = (fill_reg == NW'(dcas_pkg::QUEUE_DEPTH));
    assign empty     = (fill_reg == '0);
    assign pop_entry = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - NW'(1);
            end
        end
    end

endmodule

FILE: src/dcas_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcas_back
// Inserts stored items into a sorted register row and, at block end, shifts
// it out in the chosen order, one per cycle once the first result is ready.
// ----------------------------------------------------------------------------
module dcas_back #(
    parameter int unsigned CAPACITY = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  empty,
    input  dcas_pkg::entry_t                      entry,
    output logic                                  pop,
    output logic                                  done,
    output logic signed [dcas_pkg::VALUE_W-1:0]   sorted_value,
    output logic                                  last_res,
    output logic                                  descending,
    output logic                                  dropped
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        LOAD,
        EMIT_ASC,
        EMIT_DESC
    } state_t;

    state_t                               state_reg, state_next;
    logic signed [dcas_pkg::VALUE_W-1:0]  row_reg   [CAPACITY];
    logic signed [dcas_pkg::VALUE_W-1:0]  row_next  [CAPACITY];
    logic [CAPACITY-1:0]                  valid_reg, valid_next;
    logic [CW-1:0]                        fill_reg, fill_next;
    logic                                 desc_reg, desc_next;
    logic                                 drop_reg, drop_next;
    logic                                 done_next;
    logic signed [dcas_pkg::VALUE_W-1:0]  value_next;
    logic                                 last_next;
    logic [CAPACITY-1:0]                  gt;

    assign pop = (state_reg == LOAD) && !empty;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            gt[i] = !valid_reg[i] || (row_reg[i] > entry.value);
        end

        state_next = state_reg;
        row_next   = row_reg;
        valid_next = valid_reg;
        fill_next  = fill_reg;
        desc_next  = desc_reg;
        drop_next  = drop_reg;
        done_next  = 1'b0;
        value_next = row_reg[0];
        last_next  = 1'b0;

        case (state_reg)
            LOAD:
            begin
                if (pop)
                begin
                    if (entry.store_en)
                    begin
                        fill_next = fill_reg + CW'(1);
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (gt[i])
                            begin
                                if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                                begin
                                    row_next[i]   = row_reg[(i > 0) ? i - 1 : 0];
                                    valid_next[i] = valid_reg[(i > 0) ? i - 1 : 0];
                                end
                                else
                                begin
                                    row_next[i]   = entry.value;
                                    valid_next[i] = 1'b1;
                                end
                            end
                        end
                    end
                    if (entry.last)
                    begin
                        desc_next  = entry.descending;
                        drop_next  = entry.dropped;
                        state_next = entry.descending ? EMIT_DESC : EMIT_ASC;
                    end
                end
            end
            EMIT_ASC:
            begin
                done_next  = 1'b1;
                value_next = row_reg[0];
                last_next  = (fill_reg == CW'(1));
                fill_next  = fill_reg - CW'(1);
                for (int i = 0; i < CAPACITY - 1; i++)
                begin
                    row_next[i]   = row_reg[i + 1];
                    valid_next[i] = valid_reg[i + 1];
                end
                valid_next[CAPACITY-1] = 1'b0;
                if (fill_reg == CW'(1))
                begin
                    state_next = LOAD;
                end
            end
            EMIT_DESC:
            begin
                // shift up; emit once the largest reaches the top
                for (int i = 1; i < CAPACITY; i++)
                begin
                    row_next[i]   = row_reg[i - 1];
                    valid_next[i] = valid_reg[i - 1];
                end
                valid_next[0] = 1'b0;
                value_next    = row_reg[CAPACITY-1];
                if (valid_reg[CAPACITY-1])
                begin
                    done_next = 1'b1;
                    last_next = (fill_reg == CW'(1));
                    fill_next = fill_reg - CW'(1);
                    if (fill_reg == CW'(1))
                    begin
                        state_next = LOAD;
                    end
                end
            end
            default:
            begin
                state_next = LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LOAD;
            valid_reg <= '0;
            fill_reg  <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
            done      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        desc_reg     <= desc_next;
        drop_reg     <= drop_next;
        sorted_value <= value_next;
        last_res     <= last_next;
        descending   <= desc_reg;
        dropped      <= drop_reg;
    end

endmodule

FILE: test/direction_chosen_array_sort_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direction_chosen_array_sort_top_tb
// Loads blocks of signed values into the sort block and checks every emitted
// value, its end-of-run mark, the chosen direction and the overflow flag
// against an in-bench predictor. Directed blocks cover the extremes, both
// directions, ties and a full store; random blocks follow, sent in bursts.
// ----------------------------------------------------------------------------
module direction_chosen_array_sort_top_tb;

    localparam int unsigned CAPACITY = 8;
    localparam int unsigned TOTAL_ITEMS = 130;
    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned SETTLE_CYCLES = CAPACITY + 8;

    typedef logic signed [dcas_pkg::VALUE_W-1:0] word_t;

    localparam word_t WORD_MAX = word_t'(32'h7FFF_FFFF);
    localparam word_t WORD_MIN = word_t'(32'h8000_0000);

    typedef struct {
        word_t value;
        logic  last_res;
        logic  descending;
        logic  dropped;
    } sorted_item_t;

    class run_scoreboard;
        word_t        held_values[CAPACITY];
        int unsigned  held_count = 0;
        int unsigned  max_pos = 0;
        int unsigned  min_pos = 0;
        word_t        max_seen = '0;
        word_t        min_seen = '0;
        bit           overflow = 1'b0;
        sorted_item_t expected_run[$];
        int unsigned  mismatches = 0;

        function void note_element(word_t v, logic is_last);
            word_t        work[CAPACITY];
            word_t        key;
            int           j;
            bit           desc;
            sorted_item_t r;
            if (held_count < CAPACITY)
            begin
                held_values[held_count] = v;
                if (held_count == 0)
                begin
                    max_seen = v;
                    min_seen = v;
                    max_pos = 0;
                    min_pos = 0;
                end
                else
                begin
                    if (v > max_seen)
                    begin
                        max_seen = v;
                        max_pos = held_count;
                    end
                    if (v < min_seen)
                    begin
                        min_seen = v;
                        min_pos = held_count;
                    end
                end
                held_count++;
            end
            else
            begin
                overflow = 1'b1;
            end
            if (!is_last)
                return;
            for (int k = 0; k < held_count; k++)
                work[k] = held_values[k];
            for (int i = 1; i < held_count; i++)
            begin
                key = work[i];
                j = i;
                while (j > 0 && work[j-1] > key)
                begin
                    work[j] = work[j-1];
                    j--;
                end
                work[j] = key;
            end
            desc = max_pos > min_pos;
            for (int k = 0; k < held_count; k++)
            begin
                r.value = desc ? work[held_count-1-k] : work[k];
                r.last_res = (k + 1 == held_count);
                r.descending = desc;
                r.dropped = overflow;
                expected_run.push_back(r);
            end
            held_count = 0;
            max_pos = 0;
            min_pos = 0;
            overflow = 1'b0;
        endfunction

        function void check_result(word_t v, logic lr, logic desc, logic dr);
            sorted_item_t e;
            if (expected_run.size() == 0)
            begin
                $error("unexpected result: sorted_value %0d", v);
                mismatches++;
                return;
            end
            e = expected_run.pop_front();
            if (v !== e.value)
            begin
                $error("sorted_value: expected %0d, got %0d", e.value, v);
                mismatches++;
            end
            if (lr !== e.last_res)
            begin
                $error("last_res: expected %0b, got %0b", e.last_res, lr);
                mismatches++;
            end
            if (desc !== e.descending)
            begin
                $error("descending: expected %0b, got %0b", e.descending, desc);
                mismatches++;
            end
            if (dr !== e.dropped)
            begin
                $error("dropped: expected %0b, got %0b", e.dropped, dr);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_run.size();
        endfunction
    endclass

    logic  clk;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    word_t value = '0;
    logic  last = 1'b0;
    logic  done;
    word_t sorted_value;
    logic  last_res;
    logic  descending;
    logic  dropped;

    run_scoreboard sb = new;
    int unsigned   items_sent = 0;
    int            burst_left = 0;
    int unsigned   cycles = 0;

    direction_chosen_array_sort_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .value(value),
        .last(last),
        .done(done),
        .sorted_value(sorted_value),
        .last_res(last_res),
        .descending(descending),
        .dropped(dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(sorted_value, last_res, descending, dropped);
            if (start && !busy)
                sb.note_element(value, last);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("direction_chosen_array_sort_top_tb NOT OK");
            $finish;
        end
    end

    function automatic word_t pick_value();
        int pick;
        pick = $urandom_range(0, 4);
        case (pick)
            0: return word_t'(int'($urandom_range(0, 6)) - 3);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return WORD_MAX;
                    1: return WORD_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return word_t'($urandom());
        endcase
    endfunction

    task automatic send_item(word_t v, logic is_last);
        start <= 1'b1;
        value <= v;
        last <= is_last;
        do @(posedge clk); while (busy);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
        end
    endtask

    task automatic send_block(word_t blk[$]);
        foreach (blk[i])
            send_item(blk[i], i == blk.size() - 1);
    endtask

    // hold the sender until every expected item has come back
    task automatic hold_until_drained();
        start <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        word_t       blk[$];
        int unsigned n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        blk = {WORD_MAX};
        send_block(blk);
        blk = {WORD_MIN, WORD_MAX};
        send_block(blk);
        blk = {WORD_MAX, WORD_MIN};
        send_block(blk);
        blk = {word_t'(5), word_t'(5), word_t'(5)};
        send_block(blk);
        blk = {word_t'(0), word_t'(-1), word_t'(0), word_t'(-1)};
        send_block(blk);
        blk = {word_t'(-1), word_t'(0), word_t'(-1), word_t'(0)};
        send_block(blk);
        blk.delete();
        for (int i = 1; i <= CAPACITY + 1; i++)
            blk.push_back(word_t'(i));
        send_block(blk);
        hold_until_drained();

        while (items_sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 6) == 0)
                n = $urandom_range(CAPACITY + 1, CAPACITY + 3);
            else
                n = $urandom_range(1, CAPACITY);
            blk.delete();
            for (int i = 0; i < n; i++)
                blk.push_back(pick_value());
            send_block(blk);
            if ($urandom_range(0, 9) == 0)
                hold_until_drained();
        end
        hold_until_drained();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("direction_chosen_array_sort_top_tb OK");
        else
            $display("direction_chosen_array_sort_top_tb NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
src/dcas_pkg.sv
src/dcas_front.sv
src/dcas_queue.sv
src/dcas_back.sv
src/direction_chosen_array_sort_top.sv
test/direction_chosen_array_sort_top_tb.sv
